// ===== hw/rtl/strict_priority_task_queue_top_macros.svh =====
// Assertion macros for the strict priority task queue.
// Used by strict_priority_task_queue_top; expects i_clk and i_rst_n in scope.
`ifndef STRICT_PRIORITY_TASK_QUEUE_TOP_MACROS_SVH
`define STRICT_PRIORITY_TASK_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/spq_pkg.sv =====
// Shared types, constants and helpers for the strict priority task queue.
// No dependencies.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_WIDTH   = 8;
    localparam int LEVELS      = 3;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL_W       = 2;
    localparam int STATUS_W    = 3;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED  = 3'd0,
        ST_BLOCKED = 3'd1,
        ST_DROPPED = 3'd2,
        ST_POPPED  = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef struct packed {
        t_status               status;
        logic [LVL_W-1:0]      level;
        logic [LEVELS-1:0]     wr_en;
        logic                  rd_en;
        logic [PTR_W-1:0]      wr_addr;
        logic [PTR_W-1:0]      rd_addr;
        logic                  any_nonempty;
    } t_ctl;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        next_ptr = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

endpackage

// ===== hw/rtl/spq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/spq_ctrl.sv =====
// Queue bookkeeping: read/write pointers, fill counts and the per-request decision.
// Depends on spq_pkg.
module spq_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_process,
    input  logic                       i_command,
    input  logic [spq_pkg::LVL_W-1:0]  i_priority,
    input  logic                       i_blocked,
    output spq_pkg::t_ctl              o_ctl
);

    logic [spq_pkg::PTR_W-1:0] r_rd_ptr [spq_pkg::LEVELS];
    logic [spq_pkg::PTR_W-1:0] r_wr_ptr [spq_pkg::LEVELS];
    logic [spq_pkg::CNT_W-1:0] r_count  [spq_pkg::LEVELS];
    spq_pkg::t_ctl             w_ctl;

    always_comb begin
        w_ctl = '0;
        w_ctl.status = spq_pkg::ST_EMPTY;
        w_ctl.any_nonempty = (r_count[0] != '0) || (r_count[1] != '0) || (r_count[2] != '0);
        if (i_command == spq_pkg::CMD_PUSH) begin
            if (i_blocked) begin
                w_ctl.status = spq_pkg::ST_BLOCKED;
            end else if (i_priority >= spq_pkg::LVL_W'(spq_pkg::LEVELS)) begin
                w_ctl.status = spq_pkg::ST_DROPPED;
            end else if (r_count[i_priority] == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH)) begin
                w_ctl.status = spq_pkg::ST_DROPPED;
            end else begin
                w_ctl.status = spq_pkg::ST_PUSHED;
                w_ctl.wr_en[i_priority] = 1'b1;
                w_ctl.wr_addr = r_wr_ptr[i_priority];
            end
        end else begin
            if (r_count[0] != '0) begin
                w_ctl.status  = spq_pkg::ST_POPPED;
                w_ctl.level   = spq_pkg::LVL_W'(0);
                w_ctl.rd_en   = 1'b1;
                w_ctl.rd_addr = r_rd_ptr[0];
            end else if (r_count[1] != '0) begin
                w_ctl.status  = spq_pkg::ST_POPPED;
                w_ctl.level   = spq_pkg::LVL_W'(1);
                w_ctl.rd_en   = 1'b1;
                w_ctl.rd_addr = r_rd_ptr[1];
            end else if (r_count[2] != '0) begin
                w_ctl.status  = spq_pkg::ST_POPPED;
                w_ctl.level   = spq_pkg::LVL_W'(2);
                w_ctl.rd_en   = 1'b1;
                w_ctl.rd_addr = r_rd_ptr[2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < spq_pkg::LEVELS; l++) begin
                r_rd_ptr[l] <= '0;
                r_wr_ptr[l] <= '0;
                r_count[l]  <= '0;
            end
        end else if (i_process) begin
            for (int l = 0; l < spq_pkg::LEVELS; l++) begin
                if (w_ctl.wr_en[l]) begin
                    r_wr_ptr[l] <= spq_pkg::next_ptr(r_wr_ptr[l]);
                    r_count[l]  <= r_count[l] + 1'b1;
                end else if (w_ctl.rd_en && (w_ctl.level == spq_pkg::LVL_W'(l))) begin
                    r_rd_ptr[l] <= spq_pkg::next_ptr(r_rd_ptr[l]);
                    r_count[l]  <= r_count[l] - 1'b1;
                end
            end
        end
    end

    assign o_ctl = w_ctl;

endmodule

// ===== hw/rtl/strict_priority_task_queue_top.sv =====
// Strict three-level priority task queue, top level.
// Pipeline: an accepted request passes the request register, then the result register
// (loaded together with the queue RAM read); output back-pressure holds both.
// Throughput: one request per cycle unless the output stalls; one queue end per request.
// Reset: synchronous active-low; empties all queues and clears intake blocking. Depends on
// spq_pkg, spq_ctrl, spq_ram and strict_priority_task_queue_top_macros.svh.
`include "strict_priority_task_queue_top_macros.svh"
module strict_priority_task_queue_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_command,
    input  logic [spq_pkg::LVL_W-1:0]     i_priority_req,
    input  logic [spq_pkg::TAG_WIDTH-1:0] i_task_tag,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [spq_pkg::STATUS_W-1:0]  o_status,
    output logic [spq_pkg::TAG_WIDTH-1:0] o_out_tag,
    output logic [spq_pkg::LVL_W-1:0]     o_out_priority
);

    logic                          r_blocked;
    logic                          r_req_valid;
    logic                          r_cmd;
    logic [spq_pkg::LVL_W-1:0]     r_prio;
    logic [spq_pkg::TAG_WIDTH-1:0] r_tag;
    logic                          r_out_valid;
    spq_pkg::t_status              r_out_status;
    logic [spq_pkg::LVL_W-1:0]     r_out_level;

    logic                          w_out_free;
    logic                          w_process;
    logic                          w_accept;
    spq_pkg::t_ctl                 w_ctl;
    logic [spq_pkg::TAG_WIDTH-1:0] w_rd_data [spq_pkg::LEVELS];
    logic [spq_pkg::TAG_WIDTH-1:0] w_out_tag;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_process  = r_req_valid && w_out_free;
    assign o_in_ready = !r_req_valid || w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocked <= 1'b0;
        end else if (i_cfg_we) begin
            r_blocked <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_req_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_command;
            r_prio <= i_priority_req;
            r_tag  <= i_task_tag;
        end
    end

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_process  (w_process),
        .i_command  (r_cmd),
        .i_priority (r_prio),
        .i_blocked  (r_blocked),
        .o_ctl      (w_ctl)
    );

    for (genvar g = 0; g < spq_pkg::LEVELS; g++) begin : g_queue
        spq_ram #(
            .WIDTH (spq_pkg::TAG_WIDTH),
            .DEPTH (spq_pkg::QUEUE_DEPTH)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (w_process && w_ctl.wr_en[g]),
            .i_wr_addr (w_ctl.wr_addr),
            .i_wr_data (r_tag),
            .i_rd_en   (w_process && w_ctl.rd_en),
            .i_rd_addr (w_ctl.rd_addr),
            .o_rd_data (w_rd_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_process) begin
            r_out_status <= w_ctl.status;
            r_out_level  <= w_ctl.level;
        end
    end

    always_comb begin
        w_out_tag = '0;
        if (r_out_status == spq_pkg::ST_POPPED) begin
            case (r_out_level)
                spq_pkg::LVL_W'(0): w_out_tag = w_rd_data[0];
                spq_pkg::LVL_W'(1): w_out_tag = w_rd_data[1];
                spq_pkg::LVL_W'(2): w_out_tag = w_rd_data[2];
                default:            w_out_tag = '0;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_out_tag      = w_out_tag;
    assign o_out_priority = r_out_level;

    `SPQ_ASSERT_NEXT(a_process_gives_result, w_process, r_out_valid, "result register not loaded")
    `SPQ_ASSERT_NEXT(a_blocked_push, w_process && r_cmd == spq_pkg::CMD_PUSH && r_blocked, r_out_status == spq_pkg::ST_BLOCKED, "push not refused while blocked")
    `SPQ_ASSERT_NEXT(a_pop_nonempty, w_process && r_cmd == spq_pkg::CMD_POP && w_ctl.any_nonempty, r_out_status == spq_pkg::ST_POPPED, "pop missed a queued task")
    `SPQ_ASSERT_NOW(a_idle_level, r_out_valid && r_out_status != spq_pkg::ST_POPPED, r_out_level == '0, "level set on non-pop result")

endmodule
